[design/rsea_pkg.sv]
// ----------------------------------------------------------------------------
// Radio state energy accounter package
// Shared widths, account numbers and the account memory request type.
// ----------------------------------------------------------------------------
package rsea_pkg;

    localparam int TIME_BITS   = 32;
    localparam int POWER_BITS  = 24;
    localparam int ENERGY_BITS = 64;
    localparam int PROD_BITS   = TIME_BITS + POWER_BITS;

    localparam int NUM_ACCOUNTS = 15;
    localparam int ACCT_BITS    = 4;

    typedef logic [ACCT_BITS-1:0]   acct_t;
    typedef logic [ENERGY_BITS-1:0] energy_t;

    localparam acct_t ACCT_TOTAL     = 4'd0;
    localparam acct_t ACCT_OFF       = 4'd1;
    localparam acct_t ACCT_SLEEP     = 4'd2;
    localparam acct_t ACCT_SWITCH    = 4'd3;
    localparam acct_t ACCT_RX_IDLE   = 4'd4;
    localparam acct_t ACCT_RX_BUSY   = 4'd5;
    localparam acct_t ACCT_RX_WHOLE  = 4'd6;
    localparam acct_t ACCT_TX_IDLE   = 4'd10;
    localparam acct_t ACCT_TX_WHOLE  = 4'd11;
    localparam acct_t ACCT_NONE      = 4'd15;

    // Radio mode codes.
    localparam logic [2:0] MODE_OFF    = 3'd0;
    localparam logic [2:0] MODE_SLEEP  = 3'd1;
    localparam logic [2:0] MODE_RX     = 3'd2;
    localparam logic [2:0] MODE_TX     = 3'd3;
    localparam logic [2:0] MODE_TRX    = 3'd4;
    localparam logic [2:0] MODE_SWITCH = 3'd5;

    // Receiver and transmitter state codes.
    localparam logic [1:0] RX_IDLE      = 2'd1;
    localparam logic [1:0] RX_BUSY      = 2'd2;
    localparam logic [1:0] RX_RECEIVING = 2'd3;
    localparam logic [1:0] TX_IDLE      = 2'd1;
    localparam logic [1:0] TX_SENDING   = 2'd2;

    // Signal part codes.
    localparam logic [2:0] PART_WHOLE = 3'd1;
    localparam logic [2:0] PART_DATA  = 3'd4;

    localparam logic OP_EVENT = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef struct packed {
        logic    rd_en;
        acct_t   rd_addr;
        logic    wr_en;
        acct_t   wr_addr;
        energy_t wr_data;
    } mem_req_t;

endpackage

[design/rsea_acct_mem.sv]
// ----------------------------------------------------------------------------
// Account memory
// Fifteen 64-bit accounts, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rsea_acct_mem (
    input  logic                aclk,
    input  logic                aresetn,
    input  rsea_pkg::mem_req_t  req,
    output rsea_pkg::energy_t   rd_data
);

    rsea_pkg::energy_t mem [rsea_pkg::NUM_ACCOUNTS];
    logic [rsea_pkg::NUM_ACCOUNTS-1:0] valid_reg;
    rsea_pkg::energy_t rdata_reg;

    // An entry that was never written since reset reads as zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (req.wr_en) begin
            valid_reg[req.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rdata_reg <= valid_reg[req.rd_addr] ? mem[req.rd_addr] : '0;
        end
    end

    assign rd_data = rdata_reg;

endmodule

[design/rsea_mul.sv]
// ----------------------------------------------------------------------------
// Energy multiplier
// Registered product of elapsed ticks and power.
// ----------------------------------------------------------------------------
module rsea_mul (
    input  logic                                aclk,
    input  logic [rsea_pkg::TIME_BITS-1:0]      ticks,
    input  logic [rsea_pkg::POWER_BITS-1:0]     power,
    output logic [rsea_pkg::PROD_BITS-1:0]      energy
);

    logic [rsea_pkg::PROD_BITS-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= rsea_pkg::PROD_BITS'(ticks) * rsea_pkg::PROD_BITS'(power);
    end

    assign energy = prod_reg;

endmodule

[design/radio_state_energy_accounter.sv]
// ----------------------------------------------------------------------------
// Radio state energy accounter
// Charges radio energy to per-state accounts and reads accounts back.
// ----------------------------------------------------------------------------
// Usage:
// The s_ channel carries one beat per request. An event beat (s_op = 0)
// charges ticks since the last update times the previous power to the
// account picked by the stored previous radio state and to the total, then
// stores the new state and power. A read beat (s_op = 1) returns one account.
// Every request produces exactly one m_ beat.
// The cfg channel writes initial_power; it takes effect as the current power
// only until the first event after reset. cfg_ready is always high.
// One request is worked at a time. An event that charges reads the account
// and then the total and writes both back one after the other through the
// account memory. A read only reads its account, and an event that charges
// nothing goes straight to the result. The result beat is loaded into the
// output register at the same edge where s_ready rises again.
// A stalled m_ready holds the result beat in the output register; the block
// still takes the next request and parks its result until the beat drains.
// Reset clears all accounts, the stored state and the current power.
// ----------------------------------------------------------------------------
module radio_state_energy_accounter (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [31:0] s_time_now,
    input  logic [23:0] s_new_power,
    input  logic [2:0]  s_radio_mode,
    input  logic [1:0]  s_rx_state,
    input  logic [1:0]  s_tx_state,
    input  logic [2:0]  s_rx_part,
    input  logic [2:0]  s_tx_part,
    input  logic [3:0]  s_account_sel,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_energy_value,
    output logic [3:0]  m_charged_first,
    output logic [3:0]  m_charged_second,
    output logic        m_bad_account,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [23:0] cfg_wdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CH_ACCT,
        ST_CH_TOTAL,
        ST_WR_ACCT,
        ST_WR_TOTAL,
        ST_FINISH
    } state_t;

    state_t state_reg;

    // Stored radio state of the previous event.
    logic [rsea_pkg::TIME_BITS-1:0]  last_time_reg;
    logic [rsea_pkg::POWER_BITS-1:0] cur_power_reg;
    logic [2:0]                      prev_mode_reg;
    logic [1:0]                      prev_rx_state_reg;
    logic [1:0]                      prev_tx_state_reg;
    logic [2:0]                      prev_rx_part_reg;
    logic [2:0]                      prev_tx_part_reg;
    logic                            event_seen_reg;

    // Working registers of the request in flight.
    logic                            op_reg;
    rsea_pkg::acct_t                 target_reg;
    rsea_pkg::acct_t                 first_reg;
    rsea_pkg::acct_t                 second_reg;
    logic                            bad_reg;
    logic [rsea_pkg::TIME_BITS-1:0]  dt_reg;
    logic [rsea_pkg::POWER_BITS-1:0] power_reg;
    rsea_pkg::energy_t               acct_val_reg;
    rsea_pkg::energy_t               total_val_reg;

    // Output register.
    logic              m_valid_reg;
    rsea_pkg::energy_t m_energy_reg;
    rsea_pkg::acct_t   m_first_reg;
    rsea_pkg::acct_t   m_second_reg;
    logic              m_bad_reg;

    rsea_pkg::mem_req_t                mem_req;
    rsea_pkg::energy_t                 mem_rdata;
    logic [rsea_pkg::PROD_BITS-1:0]    charge_energy;

    rsea_acct_mem u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mem_req),
        .rd_data (mem_rdata)
    );

    rsea_mul u_mul (
        .aclk   (aclk),
        .ticks  (dt_reg),
        .power  (power_reg),
        .energy (charge_energy)
    );

    function automatic rsea_pkg::energy_t sat_add(input rsea_pkg::energy_t a,
                                                 input logic [rsea_pkg::PROD_BITS-1:0] b);
        logic [rsea_pkg::ENERGY_BITS:0] sum;
        sum = {1'b0, a} + (rsea_pkg::ENERGY_BITS+1)'(b);
        return sum[rsea_pkg::ENERGY_BITS] ? '1 : sum[rsea_pkg::ENERGY_BITS-1:0];
    endfunction

    // Account selection from the previous radio state. The receiver side and
    // the simple modes give the first account, the transmitter side the second.
    rsea_pkg::acct_t first_sel;
    rsea_pkg::acct_t second_sel;

    always_comb begin
        first_sel  = rsea_pkg::ACCT_NONE;
        second_sel = rsea_pkg::ACCT_NONE;
        unique case (prev_mode_reg)
            rsea_pkg::MODE_OFF:    first_sel = rsea_pkg::ACCT_OFF;
            rsea_pkg::MODE_SLEEP:  first_sel = rsea_pkg::ACCT_SLEEP;
            rsea_pkg::MODE_SWITCH: first_sel = rsea_pkg::ACCT_SWITCH;
            default:               first_sel = rsea_pkg::ACCT_NONE;
        endcase
        if (prev_mode_reg == rsea_pkg::MODE_RX || prev_mode_reg == rsea_pkg::MODE_TRX) begin
            unique case (prev_rx_state_reg)
                rsea_pkg::RX_IDLE: first_sel = rsea_pkg::ACCT_RX_IDLE;
                rsea_pkg::RX_BUSY: first_sel = rsea_pkg::ACCT_RX_BUSY;
                rsea_pkg::RX_RECEIVING: begin
                    if (prev_rx_part_reg >= rsea_pkg::PART_WHOLE &&
                        prev_rx_part_reg <= rsea_pkg::PART_DATA) begin
                        first_sel = rsea_pkg::ACCT_RX_WHOLE
                                    + rsea_pkg::acct_t'(prev_rx_part_reg - rsea_pkg::PART_WHOLE);
                    end
                end
                default: ;
            endcase
        end
        if (prev_mode_reg == rsea_pkg::MODE_TX || prev_mode_reg == rsea_pkg::MODE_TRX) begin
            unique case (prev_tx_state_reg)
                rsea_pkg::TX_IDLE: second_sel = rsea_pkg::ACCT_TX_IDLE;
                rsea_pkg::TX_SENDING: begin
                    if (prev_tx_part_reg >= rsea_pkg::PART_WHOLE &&
                        prev_tx_part_reg <= rsea_pkg::PART_DATA) begin
                        second_sel = rsea_pkg::ACCT_TX_WHOLE
                                     + rsea_pkg::acct_t'(prev_tx_part_reg - rsea_pkg::PART_WHOLE);
                    end
                end
                default: ;
            endcase
        end
    end

    // Only the first selected account is charged: a later charge in the same
    // event would see no elapsed time.
    rsea_pkg::acct_t                target_sel;
    logic [rsea_pkg::TIME_BITS-1:0] dt_now;
    logic                           do_charge;
    logic                           s_accept;

    assign target_sel = (first_sel != rsea_pkg::ACCT_NONE) ? first_sel : second_sel;
    assign dt_now     = s_time_now - last_time_reg;
    assign do_charge  = (target_sel != rsea_pkg::ACCT_NONE) && (dt_now != '0);
    assign s_accept   = s_valid && s_ready;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    // Memory port schedule: read the state account, read the total, then
    // write both back. The total (entry 0) never equals the state account.
    always_comb begin
        mem_req         = '0;
        mem_req.wr_data = '0;
        unique case (state_reg)
            ST_READ: begin
                mem_req.rd_en   = !bad_reg;
                mem_req.rd_addr = target_reg;
            end
            ST_CH_ACCT: begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = target_reg;
            end
            ST_CH_TOTAL: begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = rsea_pkg::ACCT_TOTAL;
            end
            ST_WR_ACCT: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = target_reg;
                mem_req.wr_data = sat_add(acct_val_reg, charge_energy);
            end
            ST_WR_TOTAL: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = rsea_pkg::ACCT_TOTAL;
                mem_req.wr_data = sat_add(total_val_reg, charge_energy);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            last_time_reg     <= '0;
            cur_power_reg     <= '0;
            prev_mode_reg     <= rsea_pkg::MODE_OFF;
            prev_rx_state_reg <= '0;
            prev_tx_state_reg <= '0;
            prev_rx_part_reg  <= '0;
            prev_tx_part_reg  <= '0;
            event_seen_reg    <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            // An event accepted in the same cycle sets the power itself.
            if (cfg_valid && cfg_ready && !event_seen_reg &&
                !(s_accept && s_op == rsea_pkg::OP_EVENT)) begin
                cur_power_reg <= cfg_wdata[rsea_pkg::POWER_BITS-1:0];
            end
            // The finish state reloads the output register on its own.
            if (m_valid_reg && m_ready && state_reg != ST_FINISH) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        op_reg     <= s_op;
                        dt_reg     <= dt_now;
                        power_reg  <= cur_power_reg;
                        if (s_op == rsea_pkg::OP_READ) begin
                            target_reg <= s_account_sel;
                            bad_reg    <= (s_account_sel == rsea_pkg::ACCT_NONE);
                            first_reg  <= rsea_pkg::ACCT_NONE;
                            second_reg <= rsea_pkg::ACCT_NONE;
                            state_reg  <= ST_READ;
                        end else begin
                            target_reg        <= target_sel;
                            bad_reg           <= 1'b0;
                            first_reg         <= first_sel;
                            second_reg        <= second_sel;
                            cur_power_reg     <= s_new_power[rsea_pkg::POWER_BITS-1:0];
                            prev_mode_reg     <= s_radio_mode;
                            prev_rx_state_reg <= s_rx_state;
                            prev_tx_state_reg <= s_tx_state;
                            prev_rx_part_reg  <= s_rx_part;
                            prev_tx_part_reg  <= s_tx_part;
                            event_seen_reg    <= 1'b1;
                            if (do_charge) begin
                                last_time_reg <= s_time_now;
                                state_reg     <= ST_CH_ACCT;
                            end else begin
                                state_reg <= ST_FINISH;
                            end
                        end
                    end
                end
                ST_READ: begin
                    state_reg <= ST_FINISH;
                end
                ST_CH_ACCT: begin
                    state_reg <= ST_CH_TOTAL;
                end
                ST_CH_TOTAL: begin
                    acct_val_reg <= mem_rdata;
                    state_reg    <= ST_WR_ACCT;
                end
                ST_WR_ACCT: begin
                    total_val_reg <= mem_rdata;
                    state_reg     <= ST_WR_TOTAL;
                end
                ST_WR_TOTAL: begin
                    state_reg <= ST_FINISH;
                end
                ST_FINISH: begin
                    // Load the output register once the previous beat is gone.
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_energy_reg <= (op_reg == rsea_pkg::OP_READ && !bad_reg)
                                        ? mem_rdata : '0;
                        m_first_reg  <= first_reg;
                        m_second_reg <= second_reg;
                        m_bad_reg    <= bad_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_energy_value   = m_energy_reg;
    assign m_charged_first  = m_first_reg;
    assign m_charged_second = m_second_reg;
    assign m_bad_account    = m_bad_reg;

`ifndef SYNTHESIS
    // No write ever lands outside the fifteen accounts.
    assert property (@(posedge aclk) disable iff (!aresetn)
        mem_req.wr_en |-> (mem_req.wr_addr != rsea_pkg::ACCT_NONE))
        else $error("account write to invalid address");

    // One request at a time: after an accept the block is busy.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while busy");

    // An invalid read returns zero energy and names no account.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_bad_account) |-> (m_energy_value == '0 &&
            m_charged_first == rsea_pkg::ACCT_NONE))
        else $error("invalid read returned data");

    // The state account is written back right before the total.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_req.wr_en && mem_req.wr_addr != rsea_pkg::ACCT_TOTAL)
            |=> (mem_req.wr_en && mem_req.wr_addr == rsea_pkg::ACCT_TOTAL))
        else $error("total not updated after account charge");
`endif

endmodule

[tb/radio_state_energy_accounter_tb.sv]
// ----------------------------------------------------------------------------
// Radio state energy accounter testbench
// Drives event and read requests with random gaps and output stalls, predicts
// every result beat from a local copy of the energy accounts, and compares
// each beat field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module radio_state_energy_accounter_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import rsea_pkg::*;

    // Codes that the package leaves unnamed. The reserved ones are legal field
    // values that select no account but are still stored as the previous state.
    localparam logic [2:0] PART_NONE     = 3'd0;
    localparam logic [2:0] PART_PREAMBLE = 3'd2;
    localparam logic [2:0] PART_HEADER   = 3'd3;
    localparam logic [2:0] PART_RSVD     = 3'd5;
    localparam logic [2:0] PART_TOP      = 3'd7;
    localparam logic [1:0] RX_UNDEF      = 2'd0;
    localparam logic [1:0] TX_UNDEF      = 2'd0;
    localparam logic [1:0] TX_RSVD       = 2'd3;
    localparam logic [2:0] MODE_RSVD_LO  = 3'd6;
    localparam logic [2:0] MODE_RSVD_HI  = 3'd7;

    localparam logic [POWER_BITS-1:0] POWER_MAX = {POWER_BITS{1'b1}};
    localparam logic [23:0]           CFG_MAX   = 24'hFF_FFFF;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 5;
    localparam int LONG_HOLD     = 250;   // receiver back-pressure stretch
    localparam int SETTLE_CYCLES = 12;    // spare idle cycles between phases
    localparam int STALL_LIMIT   = 3000;  // cycles with no handshake at all
    localparam int RANDOM_ITEMS  = 200;
    localparam int BURST_ITEMS   = 300;

    typedef struct packed {
        logic        op;
        logic [31:0] time_now;
        logic [23:0] new_power;
        logic [2:0]  radio_mode;
        logic [1:0]  rx_state;
        logic [1:0]  tx_state;
        logic [2:0]  rx_part;
        logic [2:0]  tx_part;
        acct_t       account_sel;
    } radio_req_t;

    typedef struct packed {
        energy_t energy_value;
        acct_t   charged_first;
        acct_t   charged_second;
        logic    bad_account;
    } acct_result_t;

    // Keeps its own copy of the accounts and the stored radio state, works out
    // the result of each accepted request beat and checks result beats in order.
    class energy_ledger;
        energy_t               acct_bal [NUM_ACCOUNTS];
        logic [TIME_BITS-1:0]  last_tick;
        logic [POWER_BITS-1:0] power_now;
        logic [23:0]           init_power;
        logic [2:0]            mode_q;
        logic [1:0]            rx_q;
        logic [1:0]            tx_q;
        logic [2:0]            rx_part_q;
        logic [2:0]            tx_part_q;
        bit                    event_seen;
        acct_result_t          owed [$];
        int                    errors;

        function new();
            foreach (acct_bal[i]) acct_bal[i] = '0;
            last_tick  = '0;
            power_now  = '0;
            init_power = '0;
            mode_q     = MODE_OFF;
            rx_q       = RX_UNDEF;
            tx_q       = TX_UNDEF;
            rx_part_q  = PART_NONE;
            tx_part_q  = PART_NONE;
            event_seen = 0;
            errors     = 0;
        endfunction

        // The register only sets the live power until the first event.
        function void set_initial_power(logic [23:0] value);
            init_power = value;
            if (!event_seen) power_now = value[POWER_BITS-1:0];
        endfunction

        function energy_t sat_add(energy_t a, energy_t b);
            logic [ENERGY_BITS:0] sum;
            sum = {1'b0, a} + {1'b0, b};
            return sum[ENERGY_BITS] ? {ENERGY_BITS{1'b1}} : sum[ENERGY_BITS-1:0];
        endfunction

        function acct_t part_account(acct_t whole_acct, logic [2:0] part);
            if (part >= PART_WHOLE && part <= PART_DATA)
                return whole_acct + acct_t'(part - PART_WHOLE);
            return ACCT_NONE;
        endfunction

        // A charge moves last_tick, so a second charge in the same event
        // sees no elapsed time and adds nothing.
        function void charge(acct_t idx, logic [TIME_BITS-1:0] now);
            logic [TIME_BITS-1:0] dt;
            energy_t              joules;
            dt = now - last_tick;
            if (dt == '0) return;
            joules = ENERGY_BITS'(dt) * ENERGY_BITS'(power_now);
            acct_bal[ACCT_TOTAL] = sat_add(acct_bal[ACCT_TOTAL], joules);
            acct_bal[idx]        = sat_add(acct_bal[idx], joules);
            last_tick = now;
        endfunction

        function void note_request(radio_req_t r);
            acct_result_t res;
            acct_t        first;
            acct_t        second;
            first  = ACCT_NONE;
            second = ACCT_NONE;
            if (r.op == OP_READ) begin
                res.energy_value   = (r.account_sel != ACCT_NONE) ?
                                     acct_bal[r.account_sel] : '0;
                res.charged_first  = ACCT_NONE;
                res.charged_second = ACCT_NONE;
                res.bad_account    = (r.account_sel == ACCT_NONE);
            end else begin
                case (mode_q)
                    MODE_OFF:    first = ACCT_OFF;
                    MODE_SLEEP:  first = ACCT_SLEEP;
                    MODE_SWITCH: first = ACCT_SWITCH;
                    default: ;
                endcase
                if (mode_q == MODE_RX || mode_q == MODE_TRX) begin
                    case (rx_q)
                        RX_IDLE:      first = ACCT_RX_IDLE;
                        RX_BUSY:      first = ACCT_RX_BUSY;
                        RX_RECEIVING: first = part_account(ACCT_RX_WHOLE, rx_part_q);
                        default: ;
                    endcase
                end
                if (mode_q == MODE_TX || mode_q == MODE_TRX) begin
                    case (tx_q)
                        TX_IDLE:    second = ACCT_TX_IDLE;
                        TX_SENDING: second = part_account(ACCT_TX_WHOLE, tx_part_q);
                        default: ;
                    endcase
                end
                if (first != ACCT_NONE) charge(first, r.time_now);
                if (second != ACCT_NONE) charge(second, r.time_now);
                power_now  = r.new_power[POWER_BITS-1:0];
                mode_q     = r.radio_mode;
                rx_q       = r.rx_state;
                tx_q       = r.tx_state;
                rx_part_q  = r.rx_part;
                tx_part_q  = r.tx_part;
                event_seen = 1;
                res.energy_value   = '0;
                res.charged_first  = first;
                res.charged_second = second;
                res.bad_account    = 1'b0;
            end
            owed.push_back(res);
        endfunction

        function void report_mismatch(string field, logic [63:0] want, logic [63:0] got);
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        endfunction

        function void check_result(acct_result_t got);
            acct_result_t want;
            if (owed.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat, expected none, actual %0h/%0h/%0h/%0h",
                         $time, got.energy_value, got.charged_first,
                         got.charged_second, got.bad_account);
                return;
            end
            want = owed.pop_front();
            if (got.energy_value !== want.energy_value)
                report_mismatch("energy_value", want.energy_value, got.energy_value);
            if (got.charged_first !== want.charged_first)
                report_mismatch("charged_first", 64'(want.charged_first),
                                64'(got.charged_first));
            if (got.charged_second !== want.charged_second)
                report_mismatch("charged_second", 64'(want.charged_second),
                                64'(got.charged_second));
            if (got.bad_account !== want.bad_account)
                report_mismatch("bad_account", 64'(want.bad_account), 64'(got.bad_account));
        endfunction

        function int pending();
            return owed.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_op;
    logic [31:0] s_time_now;
    logic [23:0] s_new_power;
    logic [2:0]  s_radio_mode;
    logic [1:0]  s_rx_state;
    logic [1:0]  s_tx_state;
    logic [2:0]  s_rx_part;
    logic [2:0]  s_tx_part;
    logic [3:0]  s_account_sel;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_energy_value;
    logic [3:0]  m_charged_first;
    logic [3:0]  m_charged_second;
    logic        m_bad_account;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [23:0] cfg_wdata;

    energy_ledger ledger;

    // Running radio clock in ticks. It only moves forward and is allowed to
    // wrap, since the block takes elapsed time modulo 2^32.
    logic [31:0] now_ticks;

    // Gap state for each side: a run of beats either idles at random or not
    // at all, so that both back-to-back traffic and sparse traffic show up.
    int send_run;
    bit send_calm;
    int sink_run;
    bit sink_calm;

    // Set by the stimulus to ask the receiver for one long stall.
    bit hold_sink;

    radio_state_energy_accounter u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_time_now       (s_time_now),
        .s_new_power      (s_new_power),
        .s_radio_mode     (s_radio_mode),
        .s_rx_state       (s_rx_state),
        .s_tx_state       (s_tx_state),
        .s_rx_part        (s_rx_part),
        .s_tx_part        (s_tx_part),
        .s_account_sel    (s_account_sel),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_energy_value   (m_energy_value),
        .m_charged_first  (m_charged_first),
        .m_charged_second (m_charged_second),
        .m_bad_account    (m_bad_account),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_wdata        (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #HALF_PERIOD aclk = ~aclk;
    end

    // Draws the number of idle cycles before the next beat on one side.
    // A new run starts every 8 to 40 beats, and about a third of the runs
    // have no idling at all.
    function automatic int pick_wait(inout int run_left, inout bit calm);
        if (run_left == 0) begin
            run_left = $urandom_range(8, 40);
            calm     = ($urandom_range(0, 2) == 0);
        end
        run_left--;
        return calm ? 0 : $urandom_range(0, 19);
    endfunction

    // Elapsed time between events: a fair share of zero steps (nothing gets
    // charged), mostly short steps, and some full-range steps that wrap.
    function automatic logic [31:0] pick_delta();
        case ($urandom_range(0, 9))
            0, 1:    return '0;
            2, 3, 4, 5: return $urandom_range(1, 1000);
            6, 7, 8: return $urandom_range(1, 1 << 20);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [23:0] pick_power();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return POWER_MAX;
            default: return 24'($urandom());
        endcase
    endfunction

    // Offers one request beat. Valid goes low only when a gap is drawn, so a
    // back-to-back beat keeps valid high without a second assignment in the
    // same time step. The beat is accepted at the edge where s_ready is seen
    // high; valid stays up until the caller offers the next beat or settles.
    task automatic send_beat(input radio_req_t r);
        int gap;
        gap = pick_wait(send_run, send_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_op          <= r.op;
        s_time_now    <= r.time_now;
        s_new_power   <= r.new_power;
        s_radio_mode  <= r.radio_mode;
        s_rx_state    <= r.rx_state;
        s_tx_state    <= r.tx_state;
        s_rx_part     <= r.rx_part;
        s_tx_part     <= r.tx_part;
        s_account_sel <= r.account_sel;
        do @(posedge aclk); while (s_ready !== 1'b1);
        ledger.note_request(r);
    endtask

    // Sends a state-change event; the radio clock advances by delta first.
    task automatic send_event(input logic [31:0] delta, input logic [23:0] power,
                              input logic [2:0] mode, input logic [1:0] rx,
                              input logic [1:0] tx, input logic [2:0] rx_part,
                              input logic [2:0] tx_part);
        radio_req_t r;
        now_ticks     = now_ticks + delta;
        r.op          = OP_EVENT;
        r.time_now    = now_ticks;
        r.new_power   = power;
        r.radio_mode  = mode;
        r.rx_state    = rx;
        r.tx_state    = tx;
        r.rx_part     = rx_part;
        r.tx_part     = tx_part;
        r.account_sel = acct_t'($urandom());
        send_beat(r);
    endtask

    // Sends an account read. The event fields are ignored by the block and
    // are filled with noise.
    task automatic send_read(input acct_t sel);
        radio_req_t r;
        r             = radio_req_t'($bits(radio_req_t)'({$urandom(), $urandom(),
                                                          $urandom()}));
        r.op          = OP_READ;
        r.account_sel = sel;
        send_beat(r);
    endtask

    // One random beat: about a quarter are reads, the rest events. Most
    // events carry legal codes; the others carry any bit pattern at all.
    task automatic send_random_item();
        if ($urandom_range(0, 3) == 0) begin
            send_read(acct_t'($urandom_range(0, 15)));
        end else if ($urandom_range(0, 6) != 0) begin
            send_event(pick_delta(), pick_power(),
                       3'($urandom_range(MODE_OFF, MODE_SWITCH)),
                       2'($urandom_range(0, 3)),
                       2'($urandom_range(TX_UNDEF, TX_SENDING)),
                       3'($urandom_range(PART_NONE, PART_DATA)),
                       3'($urandom_range(PART_NONE, PART_DATA)));
        end else begin
            send_event(pick_delta(), pick_power(), 3'($urandom()), 2'($urandom()),
                       2'($urandom()), 3'($urandom()), 3'($urandom()));
        end
    endtask

    // Drops valid and waits until every predicted beat has come back, then idles
    // before the next phase starts.
    task automatic settle();
        s_valid <= 1'b0;
        while (ledger.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_initial_power(input logic [23:0] value);
        cfg_valid <= 1'b1;
        cfg_wdata <= value;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        ledger.set_initial_power(value);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Stimulus and end of run.
    initial begin
        int k;
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_op          <= OP_EVENT;
        s_time_now    <= '0;
        s_new_power   <= '0;
        s_radio_mode  <= MODE_OFF;
        s_rx_state    <= RX_UNDEF;
        s_tx_state    <= TX_UNDEF;
        s_rx_part     <= PART_NONE;
        s_tx_part     <= PART_NONE;
        s_account_sel <= ACCT_TOTAL;
        cfg_valid     <= 1'b0;
        cfg_wdata     <= '0;
        ledger    = new();
        now_ticks = '0;
        send_run  = 0;
        send_calm = 0;
        hold_sink = 0;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Before the first event each write reloads the live power, so the
        // last of these two sets the live power that the first event finds.
        write_initial_power(24'($urandom_range(1, CFG_MAX - 1)));
        write_initial_power(CFG_MAX);

        // Directed walk through every account. Each event bills the state set
        // by the event before it.
        send_read(ACCT_TOTAL);
        send_read(ACCT_NONE);
        // No time has passed since reset: off is flagged but nothing is billed.
        send_event(0, 24'h000123, MODE_SLEEP, RX_UNDEF, TX_UNDEF, PART_NONE, PART_NONE);
        send_event(1000, POWER_MAX, MODE_RX, RX_IDLE, TX_UNDEF, PART_NONE, PART_NONE);
        send_event(1000, 24'h0, MODE_RX, RX_BUSY, TX_UNDEF, PART_NONE, PART_NONE);
        // Receiving with no part names no account, so the next event leaves
        // the last-update time where it was.
        send_event(1000, 24'h0001F4, MODE_RX, RX_RECEIVING, TX_UNDEF, PART_NONE, PART_NONE);
        send_event(1000, 24'h000258, MODE_RX, RX_RECEIVING, TX_IDLE, PART_WHOLE, PART_NONE);
        send_event(1000, 24'h7FFFFF, MODE_RX, RX_RECEIVING, TX_IDLE, PART_PREAMBLE,
                   PART_NONE);
        send_event(37, 24'h800000, MODE_RX, RX_RECEIVING, TX_IDLE, PART_HEADER, PART_NONE);
        send_event(5, 24'h00FF00, MODE_RX, RX_RECEIVING, TX_IDLE, PART_DATA, PART_NONE);
        send_event(99, 24'h0000AA, MODE_TX, RX_UNDEF, TX_IDLE, PART_NONE, PART_NONE);
        send_event(11, 24'h000055, MODE_TX, RX_UNDEF, TX_SENDING, PART_NONE, PART_NONE);
        send_event(13, 24'h123456, MODE_TX, RX_UNDEF, TX_SENDING, PART_NONE, PART_WHOLE);
        send_event(17, 24'h654321, MODE_TX, RX_UNDEF, TX_SENDING, PART_NONE, PART_PREAMBLE);
        send_event(19, 24'h00000F, MODE_TX, RX_UNDEF, TX_SENDING, PART_NONE, PART_HEADER);
        send_event(23, 24'h0F0F0F, MODE_TX, RX_UNDEF, TX_SENDING, PART_NONE, PART_DATA);
        // Transceiver: both sides get flagged, only the receiver side is billed.
        send_event(29, 24'h000777, MODE_TRX, RX_RECEIVING, TX_SENDING, PART_HEADER,
                   PART_DATA);
        send_event(31, 24'h000888, MODE_TRX, RX_UNDEF, TX_IDLE, PART_NONE, PART_NONE);
        // Transceiver with an undefined receiver bills the transmitter side.
        send_event(41, 24'h000999, MODE_SWITCH, RX_UNDEF, TX_UNDEF, PART_NONE, PART_NONE);
        send_event(43, 24'h000ABC, MODE_RSVD_LO, RX_IDLE, TX_IDLE, PART_NONE, PART_NONE);
        send_event(47, 24'h000DEF, MODE_RSVD_HI, RX_RECEIVING, TX_SENDING, PART_RSVD,
                   PART_TOP);
        send_event(53, 24'h001000, MODE_RX, RX_RECEIVING, TX_UNDEF, PART_TOP, PART_RSVD);
        send_event(59, POWER_MAX, MODE_TX, RX_UNDEF, TX_RSVD, PART_NONE, PART_NONE);
        // Step the clock by nearly its full range, which wraps it, and then step on.
        send_event(32'hFFFF_F000, POWER_MAX, MODE_OFF, RX_UNDEF, TX_UNDEF, PART_NONE,
                   PART_NONE);
        send_event(32'h0000_2000, 24'h000001, MODE_SLEEP, RX_UNDEF, TX_UNDEF, PART_NONE,
                   PART_NONE);
        send_read(ACCT_TX_WHOLE);

        // Once an event has been seen the register no longer changes the
        // live power; it is still written at both extremes.
        settle();
        write_initial_power('0);
        for (k = 0; k < RANDOM_ITEMS; k++) send_random_item();

        // Partway through this phase the receiver holds off for a long time
        // while requests keep coming, so the block parks a result and then
        // drops s_ready.
        settle();
        write_initial_power(24'($urandom()));
        for (k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == 40) hold_sink = 1;
            send_random_item();
        end

        // Repeated maximum charges to the off account drive it and the
        // total into saturation; reads along the way watch them get there.
        settle();
        write_initial_power(CFG_MAX);
        for (k = 0; k < BURST_ITEMS; k++) begin
            if (k % 20 == 19)
                send_read(($urandom_range(0, 1) == 0) ? ACCT_TOTAL : ACCT_OFF);
            else
                send_event(32'hFFFF_FFFF - $urandom_range(0, 255), POWER_MAX, MODE_OFF,
                           2'($urandom()), 2'($urandom()), 3'($urandom()),
                           3'($urandom()));
        end
        for (k = 0; k < 16; k++) send_read(acct_t'(k));

        settle();
        if (ledger.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Result side: stalls at random between beats and takes one long stall
    // when asked. Each accepted beat goes straight to the ledger.
    initial begin
        int           stall;
        acct_result_t got;
        sink_run  = 0;
        sink_calm = 0;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_sink) begin
                stall     = LONG_HOLD;
                hold_sink = 0;
            end else begin
                stall = pick_wait(sink_run, sink_calm);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            got.energy_value   = m_energy_value;
            got.charged_first  = m_charged_first;
            got.charged_second = m_charged_second;
            got.bad_account    = m_bad_account;
            ledger.check_result(got);
        end
    end

    // Watchdog: the run is declared hung when no channel completes a beat
    // while the quiet counter runs up to its limit.
    initial begin
        int quiet;
        quiet = 0;
        wait (aresetn === 1'b1);
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
